// ----- rtl/hca_pkg.sv -----
// Shared types, constants and register codes of the HSV color adjust block.
`default_nettype none

package hca_pkg;

  localparam int COLOR_BITS = 16;
  localparam int OUT_BITS   = COLOR_BITS + 1;
  localparam int HUE_FRAC   = 16;
  localparam int HUE_UNIT   = 1 << HUE_FRAC;
  localparam int QUO_BITS   = HUE_FRAC + 1;
  localparam int DIV_BITS   = COLOR_BITS + HUE_FRAC + 1;
  localparam int NUM_CELLS  = QUO_BITS;
  localparam int SCALE_FRAC = 14;
  localparam int CFG_BITS   = 16;
  localparam int LATENCY    = NUM_CELLS + 4;

  typedef enum logic [1:0] {
    CFG_HUE_SHIFT   = 2'd0,
    CFG_SAT_SCALE   = 2'd1,
    CFG_VAL_SCALE   = 2'd2,
    CFG_TARGET_MODE = 2'd3
  } cfg_index_t;

  localparam logic [1:0] MODE_POINT = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] alpha;
    logic                  is_fill;
    logic                  selected;
  } color_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] out_red;
    logic [OUT_BITS-1:0] out_green;
    logic [OUT_BITS-1:0] out_blue;
    logic                adjusted;
  } color_out_t;

  // One restoring-division lane as it moves down the cell row.
  typedef struct packed {
    logic [COLOR_BITS-1:0] rem;
    logic [QUO_BITS-1:0]   low;
    logic [QUO_BITS-1:0]   quo;
    logic [COLOR_BITS-1:0] divisor;
  } div_lane_t;

  // Control and pass-through data that travels beside the lanes.
  typedef struct packed {
    logic                  valid;
    logic                  adjust;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] mx;
    sector_t               sector;
    logic                  neg;
    logic                  chroma_nz;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/hca_front.sv -----
// Entry stage: max/min, hue sector and divider operands for the cell row.
`default_nettype none

module hca_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  hca_pkg::color_in_t    color,
  input  logic [1:0]            target_mode,
  output hca_pkg::side_t        side,
  output hca_pkg::div_lane_t    hue_lane,
  output hca_pkg::div_lane_t    sat_lane
);

  localparam int CB = hca_pkg::COLOR_BITS;
  localparam int DW = hca_pkg::DIV_BITS;
  localparam int QB = hca_pkg::QUO_BITS;

  logic                  covered;
  logic [CB-1:0]         mx, mn, chroma, abs_num;
  logic signed [CB:0]    num;
  hca_pkg::sector_t      sector;
  logic                  cnz;
  logic [DW-1:0]         hue_div, sat_div;
  hca_pkg::side_t        side_next;
  hca_pkg::div_lane_t    hue_next, sat_next;

  always_comb begin
    covered = color.is_fill ? (target_mode != hca_pkg::MODE_POINT)
                            : (target_mode != hca_pkg::MODE_FILL);
    mx = color.red;
    if (color.green > mx) mx = color.green;
    if (color.blue > mx) mx = color.blue;
    mn = color.red;
    if (color.green < mn) mn = color.green;
    if (color.blue < mn) mn = color.blue;
    chroma = mx - mn;
    cnz = (chroma != '0);
    // red wins ties over green, green over blue
    if (color.red >= color.green && color.red >= color.blue) begin
      sector = hca_pkg::SECT_RED;
      num = $signed({1'b0, color.green}) - $signed({1'b0, color.blue});
    end else if (color.green >= color.blue) begin
      sector = hca_pkg::SECT_GREEN;
      num = $signed({1'b0, color.blue}) - $signed({1'b0, color.red});
    end else begin
      sector = hca_pkg::SECT_BLUE;
      num = $signed({1'b0, color.red}) - $signed({1'b0, color.green});
    end
    abs_num = num[CB] ? CB'(-num) : num[CB-1:0];

    // rounded quotients: (x << 16 + d/2) / d
    hue_div = ({1'b0, abs_num, hca_pkg::HUE_FRAC'(0)}) + DW'(chroma >> 1);
    sat_div = ({1'b0, chroma, hca_pkg::HUE_FRAC'(0)}) + DW'(mx >> 1);

    hue_next.rem     = cnz ? hue_div[DW-1:QB] : '0;
    hue_next.low     = cnz ? hue_div[QB-1:0] : '0;
    hue_next.quo     = '0;
    hue_next.divisor = cnz ? chroma : CB'(1);
    sat_next.rem     = cnz ? sat_div[DW-1:QB] : '0;
    sat_next.low     = cnz ? sat_div[QB-1:0] : '0;
    sat_next.quo     = '0;
    sat_next.divisor = cnz ? mx : CB'(1);

    side_next.valid     = take;
    side_next.adjust    = color.selected && (color.alpha != '0) && covered;
    side_next.red       = color.red;
    side_next.green     = color.green;
    side_next.blue      = color.blue;
    side_next.mx        = mx;
    side_next.sector    = sector;
    side_next.neg       = num[CB];
    side_next.chroma_nz = cnz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side <= side_next;
    end
    hue_lane <= hue_next;
    sat_lane <= sat_next;
  end

endmodule

`default_nettype wire

// ----- rtl/hca_div_cell.sv -----
// One cell of the divider row: a restoring step on both lanes.
`default_nettype none

module hca_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  hca_pkg::side_t     side_in,
  input  hca_pkg::div_lane_t hue_in,
  input  hca_pkg::div_lane_t sat_in,
  output hca_pkg::side_t     side_out,
  output hca_pkg::div_lane_t hue_out,
  output hca_pkg::div_lane_t sat_out
);

  localparam int CB = hca_pkg::COLOR_BITS;
  localparam int QB = hca_pkg::QUO_BITS;

  function automatic hca_pkg::div_lane_t div_step(input hca_pkg::div_lane_t a);
    logic [CB:0]        trial;
    hca_pkg::div_lane_t b;
    b = a;
    trial = {a.rem, a.low[QB-1]};
    b.low = {a.low[QB-2:0], 1'b0};
    if (trial >= {1'b0, a.divisor}) begin
      b.rem = CB'(trial - {1'b0, a.divisor});
      b.quo = {a.quo[QB-2:0], 1'b1};
    end else begin
      b.rem = trial[CB-1:0];
      b.quo = {a.quo[QB-2:0], 1'b0};
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out <= side_in;
    end
    hue_out <= div_step(hue_in);
    sat_out <= div_step(sat_in);
  end

endmodule

`default_nettype wire

// ----- rtl/hca_back.sv -----
// Back end: hue shift and wrap, scaling, HSV to RGB and saturation.
`default_nettype none

module hca_back (
  input  logic                           clk,
  input  logic                           rst,
  input  hca_pkg::side_t                 side,
  input  logic [hca_pkg::QUO_BITS-1:0]   hue_quo,
  input  logic [hca_pkg::QUO_BITS-1:0]   sat_quo,
  input  logic [hca_pkg::CFG_BITS-1:0]   hue_shift,
  input  logic [hca_pkg::CFG_BITS-1:0]   sat_scale,
  input  logic [hca_pkg::CFG_BITS-1:0]   val_scale,
  output hca_pkg::color_out_t            result,
  output logic                           done
);

  localparam int CB = hca_pkg::COLOR_BITS;
  localparam int OB = hca_pkg::OUT_BITS;
  localparam int QB = hca_pkg::QUO_BITS;
  localparam int HW = 21;
  localparam int SPW = QB + hca_pkg::CFG_BITS - hca_pkg::SCALE_FRAC;
  localparam int VPW = CB + hca_pkg::CFG_BITS - hca_pkg::SCALE_FRAC;
  localparam int MW = QB + SPW;
  localparam logic signed [HW-1:0] U_S   = HW'(hca_pkg::HUE_UNIT);
  localparam logic signed [HW-1:0] SIX_U = HW'(6 * hca_pkg::HUE_UNIT);

  function automatic logic [HW-1:0] abs_h(input logic signed [HW-1:0] x);
    return x < 0 ? HW'(-x) : HW'(x);
  endfunction

  // (U - clamp(n)) * s'
  function automatic logic [MW-1:0] chan_prod(input logic signed [HW-1:0] n,
                                              input logic [SPW-1:0] sp);
    logic [QB-1:0] nc;
    logic [QB-1:0] t;
    if (n < 0) nc = '0;
    else if (n > U_S) nc = QB'(hca_pkg::HUE_UNIT);
    else nc = n[QB-1:0];
    t = QB'(hca_pkg::HUE_UNIT) - nc;
    return MW'(t) * MW'(sp);
  endfunction

  function automatic logic [OB-1:0] chan_out(input logic [MW-1:0] m,
                                             input logic [VPW-1:0] vp);
    logic [MW-1:0]           rnd;
    logic signed [HW-1:0]    f;
    logic [QB+VPW-1:0]       prod;
    logic [QB+VPW-17:0]      o;
    rnd = (m + MW'(32768)) >> 16;
    f = U_S - $signed(rnd[HW-1:0]);
    prod = (QB+VPW)'(f[QB-1:0]) * (QB+VPW)'(vp) + (QB+VPW)'(32768);
    o = prod[QB+VPW-1:16];
    if (f <= 0) return '0;
    else if (o > (QB+VPW-16)'({OB{1'b1}})) return {OB{1'b1}};
    else return o[OB-1:0];
  endfunction

  // stage 1
  logic                   s1_valid, s1_adj;
  logic [3*CB-1:0]        s1_rgb;
  logic signed [HW-1:0]   s1_h;
  logic [SPW-1:0]         s1_sp;
  logic [VPW-1:0]         s1_vp;
  // stage 2
  logic                   s2_valid, s2_adj;
  logic [3*CB-1:0]        s2_rgb;
  logic [MW-1:0]          s2_mr, s2_mg, s2_mb;
  logic [VPW-1:0]         s2_vp;

  logic signed [HW-1:0]   base, h0, h1, hsh;
  logic [QB+hca_pkg::CFG_BITS-1:0] sp_prod;
  logic [CB+hca_pkg::CFG_BITS-1:0] vp_prod;
  hca_pkg::color_out_t    result_next;

  always_comb begin
    case (side.sector)
      hca_pkg::SECT_RED:   base = '0;
      hca_pkg::SECT_GREEN: base = HW'(2 * hca_pkg::HUE_UNIT);
      hca_pkg::SECT_BLUE:  base = HW'(4 * hca_pkg::HUE_UNIT);
      default:             base = '0;
    endcase
    h0 = side.neg ? base - $signed(HW'(hue_quo)) : base + $signed(HW'(hue_quo));
    if (h0 < 0) h0 = h0 + SIX_U;
    if (!side.chroma_nz) h0 = '0;
    hsh = ($signed(HW'(hue_shift)) - $signed(HW'(hca_pkg::HUE_UNIT / 2))) * HW'(6);
    h1 = h0 + hsh;
    // one wrap; a full turn stays as it is
    if (h1 > SIX_U) h1 = h1 - SIX_U;
    else if (h1 < 0) h1 = h1 + SIX_U;
    sp_prod = (QB+hca_pkg::CFG_BITS)'(sat_quo) * (QB+hca_pkg::CFG_BITS)'(sat_scale)
              + (QB+hca_pkg::CFG_BITS)'(1 << (hca_pkg::SCALE_FRAC - 1));
    vp_prod = (CB+hca_pkg::CFG_BITS)'(side.mx) * (CB+hca_pkg::CFG_BITS)'(val_scale)
              + (CB+hca_pkg::CFG_BITS)'(1 << (hca_pkg::SCALE_FRAC - 1));

    if (s2_adj) begin
      result_next.out_red   = chan_out(s2_mr, s2_vp);
      result_next.out_green = chan_out(s2_mg, s2_vp);
      result_next.out_blue  = chan_out(s2_mb, s2_vp);
    end else begin
      result_next.out_red   = OB'(s2_rgb[3*CB-1:2*CB]);
      result_next.out_green = OB'(s2_rgb[2*CB-1:CB]);
      result_next.out_blue  = OB'(s2_rgb[CB-1:0]);
    end
    result_next.adjusted = s2_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= side.valid;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
    s1_adj <= side.adjust;
    s1_rgb <= {side.red, side.green, side.blue};
    s1_h   <= h1;
    s1_sp  <= sp_prod[QB+hca_pkg::CFG_BITS-1:hca_pkg::SCALE_FRAC];
    s1_vp  <= vp_prod[CB+hca_pkg::CFG_BITS-1:hca_pkg::SCALE_FRAC];

    s2_adj <= s1_adj;
    s2_rgb <= s1_rgb;
    s2_vp  <= s1_vp;
    s2_mr  <= chan_prod($signed(abs_h(s1_h - HW'(3 * hca_pkg::HUE_UNIT))) - U_S, s1_sp);
    s2_mg  <= chan_prod(HW'(2 * hca_pkg::HUE_UNIT)
                        - $signed(abs_h(s1_h - HW'(2 * hca_pkg::HUE_UNIT))), s1_sp);
    s2_mb  <= chan_prod(HW'(2 * hca_pkg::HUE_UNIT)
                        - $signed(abs_h(s1_h - HW'(4 * hca_pkg::HUE_UNIT))), s1_sp);

    result <= result_next;
  end

endmodule

`default_nettype wire

// ----- rtl/hsv_color_adjust.sv -----
// HSV color adjust: shift hue, scale saturation and value of one color word.
//
// Usage:
//   Input channel: drive a color word on color and raise start. The word is
//   taken at every rising edge where start is high and busy is low; busy
//   stays low, so a new word may enter on every clock.
//   Result channel: each taken word gives exactly one result word on result,
//   marked by done for one cycle, in input order. The receiver cannot stall.
//   Pipeline: from the taking edge to the edge that samples done, a word passes
//   one entry stage, a row of 17 divider cells (one quotient bit each, both
//   the hue and the saturation quotient side by side), three back stages.
//   Throughput: one word per cycle, set by the cell row handing its lanes on
//   in every cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index (hue shift,
//   saturation scale, value scale, target mode) at the clock edge; write only
//   while no words are in flight.
//   Reset (rst, synchronous): load the register defaults and drop every word
//   in flight; no done strobe follows words taken before reset.
`default_nettype none

module hsv_color_adjust (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hca_pkg::color_in_t            color,
  output logic                          done,
  output hca_pkg::color_out_t           result,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [hca_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int NC = hca_pkg::NUM_CELLS;

  logic [hca_pkg::CFG_BITS-1:0] hue_shift, sat_scale, val_scale;
  logic [1:0]                   target_mode;

  hca_pkg::side_t     side [NC+1];
  hca_pkg::div_lane_t hue_lane [NC+1];
  hca_pkg::div_lane_t sat_lane [NC+1];

  // never holds off the source
  assign busy = 1'b0;

  // Hold configuration registers; load defaults on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift   <= hca_pkg::CFG_BITS'(hca_pkg::HUE_UNIT / 2);
      sat_scale   <= hca_pkg::CFG_BITS'(1 << hca_pkg::SCALE_FRAC);
      val_scale   <= hca_pkg::CFG_BITS'(1 << hca_pkg::SCALE_FRAC);
      target_mode <= hca_pkg::MODE_POINT;
    end else if (cfg_we) begin
      case (hca_pkg::cfg_index_t'(cfg_index))
        hca_pkg::CFG_HUE_SHIFT:   hue_shift   <= cfg_data;
        hca_pkg::CFG_SAT_SCALE:   sat_scale   <= cfg_data;
        hca_pkg::CFG_VAL_SCALE:   val_scale   <= cfg_data;
        hca_pkg::CFG_TARGET_MODE: target_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Entry stage: sort channels, pick the hue sector, set up both dividers.
  hca_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (start && !busy),
    .color       (color),
    .target_mode (target_mode),
    .side        (side[0]),
    .hue_lane    (hue_lane[0]),
    .sat_lane    (sat_lane[0])
  );

  // Divider row: each cell settles one quotient bit and passes on.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    hca_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side[i]),
      .hue_in   (hue_lane[i]),
      .sat_in   (sat_lane[i]),
      .side_out (side[i+1]),
      .hue_out  (hue_lane[i+1]),
      .sat_out  (sat_lane[i+1])
    );
  end

  // Back end: apply the shift and scales, rebuild RGB, register the word.
  hca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .side      (side[NC]),
    .hue_quo   (hue_lane[NC].quo),
    .sat_quo   (sat_lane[NC].quo),
    .hue_shift (hue_shift),
    .sat_scale (sat_scale),
    .val_scale (val_scale),
    .result    (result),
    .done      (done)
  );

endmodule

`default_nettype wire

// ----- rtl/hca_checker.sv -----
// Port-level checks of the HSV color adjust block and their bind.
`default_nettype none

module hca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input hca_pkg::color_in_t            color,
  input logic                          done,
  input hca_pkg::color_out_t           result
);

  localparam int L = hca_pkg::LATENCY;

  a_take_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##L done)
    else $error("taken word gave no result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, L))
    else $error("result without a taken word");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && !result.adjusted) |->
      (result.out_red == hca_pkg::OUT_BITS'($past(color.red, L)) &&
       result.out_blue == hca_pkg::OUT_BITS'($past(color.blue, L))))
    else $error("pass-through word changed");

  a_adjust_needs_select: assert property (@(posedge clk) disable iff (rst)
    (done && result.adjusted) |->
      ($past(color.selected, L) && $past(color.alpha, L) != '0))
    else $error("adjusted an unselected or transparent word");

endmodule

bind hsv_color_adjust hca_checker u_hca_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .color  (color),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the HSV color adjust block.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  hca_pkg::color_in_t           color = '0;
  logic                         done;
  hca_pkg::color_out_t          result;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_index = hca_pkg::CFG_HUE_SHIFT;
  logic [hca_pkg::CFG_BITS-1:0] cfg_data = '0;

  // Local copy of the adjust registers used by the predictor.
  logic [15:0] hue_shift_q;
  logic [15:0] sat_scale_q;
  logic [15:0] val_scale_q;
  logic [1:0]  target_mode_q;

  hca_pkg::color_out_t expected_colors[$];
  int                  fail_count = 0;
  int                  idle_cycles = 0;
  bit                  quiet_tail = 1'b0;

  hsv_color_adjust i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .color(color),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Report one mismatch and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Back conversion of one channel from its triangle position.
  function automatic longint channel_level(longint n, longint s, longint v);
    longint nc;
    longint f;
    longint o;
    nc = n < 0 ? 0 : (n > hca_pkg::HUE_UNIT ? hca_pkg::HUE_UNIT : n);
    f = hca_pkg::HUE_UNIT - (((hca_pkg::HUE_UNIT - nc) * s + 32768) >>> 16);
    if (f <= 0) return 0;
    o = (f * v + 32768) >>> 16;
    return o > 131071 ? 131071 : o;
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Predict the adjusted color for one input word.
  function automatic hca_pkg::color_out_t predict_color(hca_pkg::color_in_t c);
    hca_pkg::color_out_t o;
    longint r, g, b, mx, mn, ch, h, s, base, num, q, sp, vp;
    bit covered;
    r = c.red; g = c.green; b = c.blue;
    covered = c.is_fill ? (target_mode_q != hca_pkg::MODE_POINT)
                        : (target_mode_q != hca_pkg::MODE_FILL);
    o.out_red = 17'(r); o.out_green = 17'(g); o.out_blue = 17'(b); o.adjusted = 1'b0;
    if (!c.selected || c.alpha == 0 || !covered) return o;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    ch = mx - mn; h = 0; s = 0;
    if (ch > 0) begin
      if (r >= g && r >= b) begin
        base = 0; num = g - b;
      end else if (g >= b) begin
        base = 2 * hca_pkg::HUE_UNIT; num = b - r;
      end else begin
        base = 4 * hca_pkg::HUE_UNIT; num = r - g;
      end
      q = ((mag(num) << 16) + ch / 2) / ch;
      h = base + (num < 0 ? -q : q);
      if (h < 0) h += 6 * hca_pkg::HUE_UNIT;
      s = ((ch << 16) + mx / 2) / mx;
    end
    h += (longint'(hue_shift_q) - 32768) * 6;
    if (h > 6 * hca_pkg::HUE_UNIT) h -= 6 * hca_pkg::HUE_UNIT;
    else if (h < 0) h += 6 * hca_pkg::HUE_UNIT;
    sp = (s * longint'(sat_scale_q) + 8192) >>> 14;
    vp = (mx * longint'(val_scale_q) + 8192) >>> 14;
    o.out_red   = 17'(channel_level(mag(h - 3 * hca_pkg::HUE_UNIT) - hca_pkg::HUE_UNIT,
                                    sp, vp));
    o.out_green = 17'(channel_level(2 * hca_pkg::HUE_UNIT - mag(h - 2 * hca_pkg::HUE_UNIT),
                                    sp, vp));
    o.out_blue  = 17'(channel_level(2 * hca_pkg::HUE_UNIT - mag(h - 4 * hca_pkg::HUE_UNIT),
                                    sp, vp));
    o.adjusted = 1'b1;
    return o;
  endfunction

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected result word", longint'(result), 0);
      end else begin
        hca_pkg::color_out_t e;
        e = expected_colors.pop_front();
        if (result.out_red != e.out_red) report_mismatch("out_red", result.out_red, e.out_red);
        if (result.out_green != e.out_green)
          report_mismatch("out_green", result.out_green, e.out_green);
        if (result.out_blue != e.out_blue)
          report_mismatch("out_blue", result.out_blue, e.out_blue);
        if (result.adjusted != e.adjusted)
          report_mismatch("adjusted", result.adjusted, e.adjusted);
      end
    end
  end

  // Watchdog: count cycles where no word moves on either side and no register is written.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hsv_color_adjust: mismatch");
      $finish;
    end
  end

  // Send one color word, with an optional random gap before it.
  task automatic send_color(input hca_pkg::color_in_t c);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    color <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_colors.push_back(predict_color(c));
  endtask

  // Hold start low until all predictions are met, then let the pipe drain.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (hca_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input hca_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hca_pkg::CFG_HUE_SHIFT:   hue_shift_q = value;
      hca_pkg::CFG_SAT_SCALE:   sat_scale_q = value;
      hca_pkg::CFG_VAL_SCALE:   val_scale_q = value;
      hca_pkg::CFG_TARGET_MODE: target_mode_q = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] hs, input logic [15:0] ss,
                          input logic [15:0] vs, input logic [1:0] md);
    write_reg(hca_pkg::CFG_HUE_SHIFT, hs);
    write_reg(hca_pkg::CFG_SAT_SCALE, ss);
    write_reg(hca_pkg::CFG_VAL_SCALE, vs);
    write_reg(hca_pkg::CFG_TARGET_MODE, 16'(md));
  endtask

  function automatic hca_pkg::color_in_t make_color(logic [15:0] r, logic [15:0] g,
                                                    logic [15:0] b, logic [15:0] a,
                                                    logic f, logic s);
    hca_pkg::color_in_t c;
    c.red = r; c.green = g; c.blue = b; c.alpha = a; c.is_fill = f; c.selected = s;
    return c;
  endfunction

  function automatic hca_pkg::color_in_t random_color();
    hca_pkg::color_in_t c;
    c = make_color(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 1'($urandom));
    // Mostly selected, opaque-ish words so the adjust path gets exercised.
    if ($urandom_range(0, 9) < 8) begin
      c.selected = 1'b1;
      if (c.alpha == 0) c.alpha = 16'd1;
    end
    case ($urandom_range(0, 9))
      0: begin
        c.green = c.red; c.blue = c.red;   // grey
      end
      1: c.green = c.red;                  // red and green tie
      2: c.blue = c.green;                 // green and blue tie
      3: c.red = 16'($urandom_range(0, 3));
      default: ;
    endcase
    return c;
  endfunction

  // Extremes, every tie, grey, black, gating by alpha, select and mode.
  task automatic test_directed();
    send_color(make_color(16'hFFFF, 0, 0, 16'hFFFF, 0, 1));
    send_color(make_color(0, 16'hFFFF, 0, 16'hFFFF, 0, 1));
    send_color(make_color(0, 0, 16'hFFFF, 16'hFFFF, 0, 1));
    send_color(make_color(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1));
    send_color(make_color(0, 0, 0, 16'hFFFF, 0, 1));
    send_color(make_color(16'h8000, 16'h8000, 16'h8000, 1, 0, 1));
    send_color(make_color(16'hFFFF, 16'hFFFF, 16'h1234, 16'h8000, 0, 1));
    send_color(make_color(16'h1234, 16'hFFFF, 16'hFFFF, 16'h8000, 0, 1));
    send_color(make_color(16'hFFFF, 16'h1234, 16'hFFFF, 16'h8000, 0, 1));
    send_color(make_color(16'h4000, 16'h2000, 16'h6000, 0, 0, 1));
    send_color(make_color(16'h4000, 16'h2000, 16'h6000, 16'hFFFF, 0, 0));
    send_color(make_color(16'h4000, 16'h2000, 16'h6000, 16'hFFFF, 1, 1));
    send_color(make_color(16'h0001, 0, 16'h0002, 16'h0001, 0, 1));
    drain_pipe();
  endtask

  // Hue shift extremes: wrap above one turn and below zero.
  task automatic test_hue_wrap();
    set_regs(16'hFFFF, 16'd16384, 16'd16384, 2'd2);
    send_color(make_color(16'hFFFF, 16'h8000, 0, 16'hFFFF, 1, 1));
    send_color(make_color(16'h8000, 0, 16'hFFFF, 16'hFFFF, 0, 1));
    drain_pipe();
    set_regs(16'h0000, 16'd16384, 16'd16384, 2'd2);
    send_color(make_color(16'hFFFF, 0, 16'h0100, 16'hFFFF, 1, 1));
    send_color(make_color(16'hFFFF, 16'h0100, 0, 16'hFFFF, 0, 1));
    send_color(make_color(16'hFFFF, 0, 0, 16'hFFFF, 0, 1));
    drain_pipe();
  endtask

  // Scale extremes, out-of-range scales and the unused mode codes.
  task automatic test_scales_modes();
    set_regs(16'h8000, 16'd0, 16'd0, 2'd1);
    send_color(make_color(16'hFFFF, 16'h1000, 16'h2000, 16'hFFFF, 1, 1));
    send_color(make_color(16'hFFFF, 16'h1000, 16'h2000, 16'hFFFF, 0, 1));
    drain_pipe();
    set_regs(16'h2AAA, 16'd32768, 16'd32768, 2'd3);
    send_color(make_color(16'hFFFF, 16'h1000, 16'h2000, 16'hFFFF, 1, 1));
    send_color(make_color(16'h9000, 16'h1000, 16'hF000, 16'hFFFF, 0, 1));
    drain_pipe();
    set_regs(16'h5555, 16'hFFFF, 16'hFFFF, 2'd2);
    send_color(make_color(16'hFFFF, 16'h1000, 16'h2000, 16'hFFFF, 1, 1));
    send_color(make_color(16'h3000, 16'hC000, 16'h0000, 16'hFFFF, 0, 1));
    drain_pipe();
  endtask

  // Random words over a series of random register settings.
  task automatic test_random();
    for (int phase = 0; phase < 9; phase++) begin
      set_regs(16'($urandom),
               16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768)),
               16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768)),
               2'($urandom_range(0, 3)));
      if (phase == 8) quiet_tail = 1'b1;
      for (int k = 0; k < 100; k++) send_color(random_color());
      drain_pipe();
    end
  endtask

  initial begin
    hue_shift_q = 16'd32768;
    sat_scale_q = 16'd16384;
    val_scale_q = 16'd16384;
    target_mode_q = hca_pkg::MODE_POINT;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_hue_wrap();
    test_scales_modes();
    test_random();
    if (fail_count == 0 && expected_colors.size() == 0) begin
      $display("hsv_color_adjust: match");
    end else begin
      $display("hsv_color_adjust: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hca_pkg.sv
rtl/hca_front.sv
rtl/hca_div_cell.sv
rtl/hca_back.sv
rtl/hsv_color_adjust.sv
rtl/hca_checker.sv
tb/tb.sv
